### sv/slfs_pkg.sv
// Shared types, codes and helpers for the serpentine LED frame streamer.
package slfs_pkg;

  localparam int KIND_W   = 3;
  localparam int ROW_W    = 3;
  localparam int COLUMN_W = 6;
  localparam int CHAN_W   = 8;
  localparam int LED_W    = 9;
  localparam int BRIGHT_W = 8;
  localparam int ACOLS_W  = 7;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [KIND_W-1:0] KIND_WRITE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd2;
  localparam logic [KIND_W-1:0] KIND_START = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NEXT  = 3'd4;

  localparam logic REG_BRIGHTNESS     = 1'b0;
  localparam logic REG_ACTIVE_COLUMNS = 1'b1;

  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 8'd32;
  localparam logic [ACOLS_W-1:0]  MIN_COLS     = 7'd32;

  typedef struct packed {
    logic take;
    logic sweep;
    logic mul;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic out_free;
  } dp_status_t;

  // floor(p / 255) for p up to 255*255
  function automatic logic [CHAN_W-1:0] div255(input logic [15:0] p);
    logic [16:0] t;
    t = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

### sv/slfs_if.sv
// Item and result channel interfaces.
interface slfs_req_if;
  logic                          valid;
  logic                          ready;
  logic [slfs_pkg::KIND_W-1:0]   kind;
  logic [slfs_pkg::ROW_W-1:0]    row;
  logic [slfs_pkg::COLUMN_W-1:0] column;
  logic [slfs_pkg::CHAN_W-1:0]   red_in;
  logic [slfs_pkg::CHAN_W-1:0]   green_in;
  logic [slfs_pkg::CHAN_W-1:0]   blue_in;

  modport source (output valid, kind, row, column, red_in, green_in, blue_in, input ready);
  modport sink (input valid, kind, row, column, red_in, green_in, blue_in, output ready);
endinterface

interface slfs_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [slfs_pkg::CHAN_W-1:0] green_out;
  logic [slfs_pkg::CHAN_W-1:0] red_out;
  logic [slfs_pkg::CHAN_W-1:0] blue_out;
  logic                        from_stream;
  logic [slfs_pkg::LED_W-1:0]  led_number;
  logic                        last_led;

  modport source (output valid, green_out, red_out, blue_out, from_stream, led_number,
                  last_led, input ready);
  modport sink (input valid, green_out, red_out, blue_out, from_stream, led_number,
                last_led, output ready);
endinterface

### sv/slfs_regs.sv
// APB configuration registers: brightness and active column count.
module slfs_regs #(
  parameter int MAX_COLS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [slfs_pkg::APB_AW-1:0]   paddr,
  input  logic [slfs_pkg::APB_DW-1:0]   pwdata,
  output logic [slfs_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output logic [slfs_pkg::BRIGHT_W-1:0] brightness,
  output logic [slfs_pkg::ACOLS_W-1:0]  active_columns
);
  import slfs_pkg::*;

  logic                wr_en;
  logic                reg_sel;
  logic [ACOLS_W-1:0]  cols_raw;
  logic [ACOLS_W-1:0]  cols_clamped;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];
  assign cols_raw = pwdata[ACOLS_W-1:0];

  always_comb begin
    cols_clamped = cols_raw;
    if (cols_raw < MIN_COLS) begin
      cols_clamped = MIN_COLS;
    end else if (32'(cols_raw) > MAX_COLS) begin
      cols_clamped = ACOLS_W'(MAX_COLS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness     <= BRIGHT_RESET;
      active_columns <= MIN_COLS;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_BRIGHTNESS:     brightness <= pwdata[BRIGHT_W-1:0];
        REG_ACTIVE_COLUMNS: active_columns <= cols_clamped;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BRIGHTNESS:     prdata = {{(APB_DW-BRIGHT_W){1'b0}}, brightness};
      REG_ACTIVE_COLUMNS: prdata = {{(APB_DW-ACOLS_W){1'b0}}, active_columns};
      default:            prdata = '0;
    endcase
  end

endmodule

### sv/slfs_ctrl.sv
// Controller: intake, store clearing sweep and result sequencing.
module slfs_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic [slfs_pkg::KIND_W-1:0] req_kind,
  output logic                        req_ready,
  input  slfs_pkg::dp_status_t        st,
  output slfs_pkg::dp_cmd_t           cmd
);
  import slfs_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_MUL   = 2'd2;
  localparam logic [1:0] ST_LOAD  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.sweep = 1'b1;
        if (st.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.take  = req_valid;
        if (req_valid) begin
          case (req_kind) inside
            KIND_READ, KIND_NEXT: state_next = ST_MUL;
            KIND_CLEAR:           state_next = ST_CLEAR;
            default:              state_next = ST_IDLE;
          endcase
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (st.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

### sv/slfs_dp.sv
// Datapath: frame store, serpentine stream pointer, scaling and result register.
module slfs_dp #(
  parameter int ROWS     = 8,
  parameter int MAX_COLS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  slfs_pkg::dp_cmd_t             cmd,
  output slfs_pkg::dp_status_t          st,
  input  logic [slfs_pkg::KIND_W-1:0]   kind,
  input  logic [slfs_pkg::ROW_W-1:0]    row,
  input  logic [slfs_pkg::COLUMN_W-1:0] column,
  input  logic [slfs_pkg::CHAN_W-1:0]   red_in,
  input  logic [slfs_pkg::CHAN_W-1:0]   green_in,
  input  logic [slfs_pkg::CHAN_W-1:0]   blue_in,
  input  logic [slfs_pkg::BRIGHT_W-1:0] brightness,
  input  logic [slfs_pkg::ACOLS_W-1:0]  active_columns,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [slfs_pkg::CHAN_W-1:0]   green_out,
  output logic [slfs_pkg::CHAN_W-1:0]   red_out,
  output logic [slfs_pkg::CHAN_W-1:0]   blue_out,
  output logic                          from_stream,
  output logic [slfs_pkg::LED_W-1:0]    led_number,
  output logic                          last_led
);
  import slfs_pkg::*;

  localparam int SW    = $clog2(ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int AW    = SW + CW;
  localparam int DEPTH = ROWS << CW;
  localparam int PIX_W = 3 * CHAN_W;

  logic [PIX_W-1:0] mem [DEPTH];

  logic [SW+ROW_W-1:0]    row_w;
  logic [CW+COLUMN_W-1:0] col_w;
  logic [SW-1:0]          row_idx;
  logic [CW-1:0]          col_idx;
  logic                   pix_ok;

  logic [CW-1:0] chain_col;
  logic [SW-1:0] chain_step;
  logic          stale;
  logic [CW-1:0] eff_col;
  logic [SW-1:0] eff_step;
  logic [SW-1:0] eff_row;
  logic          step_end;
  logic          take_last;
  logic [LED_W-1:0] take_led;

  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic [PIX_W-1:0] wr_data;
  logic             wr_en;
  logic [AW-1:0]    sweep_addr;

  logic [PIX_W-1:0] rd_data;
  logic             item_stream;
  logic             item_ok;
  logic             item_last;
  logic [LED_W-1:0] item_led;
  logic [15:0]      prod_g;
  logic [15:0]      prod_r;
  logic [15:0]      prod_b;

  assign row_w   = (SW+ROW_W)'(row);
  assign col_w   = (CW+COLUMN_W)'(column);
  assign row_idx = row_w[SW-1:0];
  assign col_idx = col_w[CW-1:0];
  assign pix_ok  = (32'(row) < ROWS) && (32'(column) < 32'(active_columns))
                   && (32'(column) < MAX_COLS);

  assign stale     = 32'(chain_col) >= 32'(active_columns);
  assign eff_col   = stale ? '0 : chain_col;
  assign eff_step  = stale ? '0 : chain_step;
  assign eff_row   = eff_col[0] ? (SW'(ROWS - 1) - eff_step) : eff_step;
  assign step_end  = 32'(eff_step) == ROWS - 1;
  assign take_last = step_end && (32'(eff_col) + 32'd1 == 32'(active_columns));
  assign take_led  = LED_W'(32'(eff_col) * ROWS + 32'(eff_step));

  assign rd_addr = (kind == KIND_NEXT) ? {eff_row, eff_col} : {row_idx, col_idx};

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {row_idx, col_idx};
    wr_data = {red_in, green_in, blue_in};
    if (cmd.sweep) begin
      wr_en   = 1'b1;
      wr_addr = sweep_addr;
      wr_data = '0;
    end else if (cmd.take && kind == KIND_WRITE && pix_ok) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.take) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign st.sweep_last = 32'(sweep_addr) == DEPTH - 1;
  assign st.out_free   = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      chain_col  <= '0;
      chain_step <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd.take && kind == KIND_CLEAR) begin
        sweep_addr <= '0;
      end else if (cmd.sweep) begin
        sweep_addr <= sweep_addr + 1'b1;
      end
      if (cmd.take && kind == KIND_START) begin
        chain_col  <= '0;
        chain_step <= '0;
      end else if (cmd.take && kind == KIND_NEXT) begin
        if (take_last) begin
          chain_col  <= '0;
          chain_step <= '0;
        end else if (step_end) begin
          chain_col  <= eff_col + 1'b1;
          chain_step <= '0;
        end else begin
          chain_col  <= eff_col;
          chain_step <= eff_step + 1'b1;
        end
      end
      if (cmd.load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_stream <= kind == KIND_NEXT;
      item_ok     <= pix_ok;
      item_last   <= take_last;
      item_led    <= take_led;
    end
    if (cmd.mul) begin
      prod_g <= rd_data[15:8] * brightness;
      prod_r <= rd_data[23:16] * brightness;
      prod_b <= rd_data[7:0] * brightness;
    end
    if (cmd.load) begin
      if (item_stream) begin
        green_out <= div255(prod_g);
        red_out   <= div255(prod_r);
        blue_out  <= div255(prod_b);
      end else if (item_ok) begin
        green_out <= rd_data[15:8];
        red_out   <= rd_data[23:16];
        blue_out  <= rd_data[7:0];
      end else begin
        green_out <= '0;
        red_out   <= '0;
        blue_out  <= '0;
      end
      from_stream <= item_stream;
      led_number  <= item_stream ? item_led : '0;
      last_led    <= item_stream && item_last;
    end
  end

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(chain_step) < ROWS)
    else $error("stream step beyond row count");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> st.out_free)
    else $error("result register overwritten");

  a_wrap_after_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && kind == KIND_NEXT && take_last) |=> (chain_col == '0 && chain_step == '0))
    else $error("stream pointer did not wrap after last LED");

  a_read_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !from_stream) |-> (led_number == '0 && !last_led))
    else $error("read result carries stream fields");

endmodule

### sv/serpentine_led_frame_streamer.sv
// Serpentine LED frame streamer: an RGB frame store of ROWS x MAX_COLS pixels with
// pixel write/read, clear, and a column-major serpentine LED stream scaled by brightness.
// Write pixel, start frame and unused kinds finish when taken. Read pixel and next LED pass
// through a registered store read, a channel multiply and a load into the result register,
// plus any wait for it to drain; only next LED results are scaled, with the divide-by-255
// correction at the load. Clear all, and the pass that follows reset, sweep the store one
// entry per cycle through its single write port, ROWS * 2**ceil(log2(MAX_COLS)) entries,
// 512 at the defaults, with intake held off. Configuration writes are taken at any time.
module serpentine_led_frame_streamer #(
  parameter int ROWS     = 8,
  parameter int MAX_COLS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  slfs_req_if.sink                    req,
  slfs_rsp_if.source                  rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [slfs_pkg::APB_AW-1:0] paddr,
  input  logic [slfs_pkg::APB_DW-1:0] pwdata,
  output logic [slfs_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import slfs_pkg::*;

  logic [BRIGHT_W-1:0] brightness;
  logic [ACOLS_W-1:0]  active_columns;
  dp_cmd_t             cmd;
  dp_status_t          st;

  slfs_regs #(
    .MAX_COLS (MAX_COLS)
  ) u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .brightness     (brightness),
    .active_columns (active_columns)
  );

  slfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_kind  (req.kind),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd)
  );

  slfs_dp #(
    .ROWS     (ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .kind           (req.kind),
    .row            (req.row),
    .column         (req.column),
    .red_in         (req.red_in),
    .green_in       (req.green_in),
    .blue_in        (req.blue_in),
    .brightness     (brightness),
    .active_columns (active_columns),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .green_out      (rsp.green_out),
    .red_out        (rsp.red_out),
    .blue_out       (rsp.blue_out),
    .from_stream    (rsp.from_stream),
    .led_number     (rsp.led_number),
    .last_led       (rsp.last_led)
  );

endmodule
